>>> sv/i2cseq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cseq_pkg;

  localparam logic [1:0] MODE_REQUEST = 2'd0;
  localparam logic [1:0] MODE_EVENT   = 2'd1;
  localparam logic [1:0] MODE_LOAD    = 2'd2;

  localparam logic TARGET_CMD = 1'b0;
  localparam logic TARGET_TX  = 1'b1;

  localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
  localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_TX    = 3'd3,
    ACT_RCEN  = 3'd4,
    ACT_ACK   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    SRC_LITERAL = 2'd0,
    SRC_CMD     = 2'd1,
    SRC_TX      = 2'd2
  } tx_src_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       transfer_kind;
    logic [7:0] device_address;
    logic [4:0] command_length;
    logic [6:0] tx_length;
    logic [6:0] rx_length;
    logic       ack_status;
    logic [7:0] bus_rx_byte;
  } req_t;

  typedef struct packed {
    action_t    action;
    tx_src_t    src;
    logic [7:0] byte_val;
    logic       nack;
    logic       rxv;
    logic [5:0] rxi;
    logic [7:0] rxd;
    logic       fin;
    logic       ok;
    logic       acc;
    logic [6:0] rd_idx;
  } step_t;

endpackage

`default_nettype wire

>>> sv/i2cseq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface i2cseq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       transfer_kind;
  logic [7:0] device_address;
  logic [4:0] command_length;
  logic [6:0] tx_length;
  logic [6:0] rx_length;
  logic       ack_status;
  logic [7:0] bus_rx_byte;
  logic       load_target;
  logic [5:0] load_index;
  logic [7:0] load_byte;

  modport source (
    output valid, mode, transfer_kind, device_address, command_length, tx_length,
           rx_length, ack_status, bus_rx_byte, load_target, load_index, load_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, transfer_kind, device_address, command_length, tx_length,
           rx_length, ack_status, bus_rx_byte, load_target, load_index, load_byte,
    output ready
  );
endinterface

interface i2cseq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_action;
  logic [7:0] tx_byte;
  logic       nack_bit;
  logic       rx_valid;
  logic [5:0] rx_index;
  logic [7:0] rx_data;
  logic       finished;
  logic       succeeded;
  logic       accepted;

  modport source (
    output valid, bus_action, tx_byte, nack_bit, rx_valid, rx_index, rx_data,
           finished, succeeded, accepted,
    input  ready
  );
  modport sink (
    input  valid, bus_action, tx_byte, nack_bit, rx_valid, rx_index, rx_data,
           finished, succeeded, accepted,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/i2c_master_transaction_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A result word passes through the control step register, with the store read
// registered alongside it, and then through the output register.
// Throughput: one word per cycle; the input stalls only while the step register
// and the output register both hold words and the result side is not ready.
// Reset: phase, counters and handshake state clear; the command and transmit
// stores are not cleared and must be loaded before their entries are read.

module i2c_master_transaction_sequencer_core #(
  parameter int COMMAND_DEPTH = 16,
  parameter int DATA_DEPTH    = 64
) (
  input wire logic    clk,
  input wire logic    rst_n,
  i2cseq_in_if.sink   in_ch,
  i2cseq_out_if.source out_ch
);

  localparam int CAW = (COMMAND_DEPTH > 1) ? $clog2(COMMAND_DEPTH) : 1;
  localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  i2cseq_pkg::req_t  req;
  i2cseq_pkg::step_t step;
  i2cseq_pkg::step_t s1_r;
  logic              s1_v_r;
  logic              s1_cmd_ok_r, s1_tx_ok_r;
  logic              out_v_r;
  logic              take, move;
  logic [31:0]       rd_idx32, ld_idx32;
  logic              cmd_ok, tx_ok, ld_cmd, ld_tx;
  logic [7:0]        cmd_rdata, tx_rdata, tx_byte_sel;

  logic [2:0] o_action_r;
  logic [7:0] o_txb_r;
  logic       o_nack_r, o_rxv_r, o_fin_r, o_ok_r, o_acc_r;
  logic [5:0] o_rxi_r;
  logic [7:0] o_rxd_r;

  assign move        = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || move;
  assign take        = in_ch.valid && in_ch.ready;

  assign req.mode           = in_ch.mode;
  assign req.transfer_kind  = in_ch.transfer_kind;
  assign req.device_address = in_ch.device_address;
  assign req.command_length = in_ch.command_length;
  assign req.tx_length      = in_ch.tx_length;
  assign req.rx_length      = in_ch.rx_length;
  assign req.ack_status     = in_ch.ack_status;
  assign req.bus_rx_byte    = in_ch.bus_rx_byte;

  i2cseq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .req   (req),
    .step  (step)
  );

  assign rd_idx32 = 32'(step.rd_idx);
  assign ld_idx32 = 32'(in_ch.load_index);
  assign cmd_ok   = rd_idx32 < 32'(COMMAND_DEPTH);
  assign tx_ok    = rd_idx32 < 32'(DATA_DEPTH);
  assign ld_cmd   = take && in_ch.mode == i2cseq_pkg::MODE_LOAD
                    && in_ch.load_target == i2cseq_pkg::TARGET_CMD
                    && ld_idx32 < 32'(COMMAND_DEPTH);
  assign ld_tx    = take && in_ch.mode == i2cseq_pkg::MODE_LOAD
                    && in_ch.load_target == i2cseq_pkg::TARGET_TX
                    && ld_idx32 < 32'(DATA_DEPTH);

  i2cseq_ram #(.WIDTH(8), .DEPTH(COMMAND_DEPTH)) u_cmd_ram (
    .clk   (clk),
    .we    (ld_cmd),
    .waddr (ld_idx32[CAW-1:0]),
    .wdata (in_ch.load_byte),
    .re    (take),
    .raddr (rd_idx32[CAW-1:0]),
    .rdata (cmd_rdata)
  );

  i2cseq_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (ld_tx),
    .waddr (ld_idx32[DAW-1:0]),
    .wdata (in_ch.load_byte),
    .re    (take),
    .raddr (rd_idx32[DAW-1:0]),
    .rdata (tx_rdata)
  );

  always_comb begin
    case (s1_r.src)
      i2cseq_pkg::SRC_CMD: tx_byte_sel = s1_cmd_ok_r ? cmd_rdata : 8'd0;
      i2cseq_pkg::SRC_TX:  tx_byte_sel = s1_tx_ok_r ? tx_rdata : 8'd0;
      default:             tx_byte_sel = s1_r.byte_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (take) begin
        s1_v_r <= 1'b1;
      end else if (move) begin
        s1_v_r <= 1'b0;
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r        <= step;
      s1_cmd_ok_r <= cmd_ok;
      s1_tx_ok_r  <= tx_ok;
    end
    if (move) begin
      o_action_r <= s1_r.action;
      o_txb_r    <= tx_byte_sel;
      o_nack_r   <= s1_r.nack;
      o_rxv_r    <= s1_r.rxv;
      o_rxi_r    <= s1_r.rxi;
      o_rxd_r    <= s1_r.rxd;
      o_fin_r    <= s1_r.fin;
      o_ok_r     <= s1_r.ok;
      o_acc_r    <= s1_r.acc;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.bus_action = o_action_r;
  assign out_ch.tx_byte    = o_txb_r;
  assign out_ch.nack_bit   = o_nack_r;
  assign out_ch.rx_valid   = o_rxv_r;
  assign out_ch.rx_index   = o_rxi_r;
  assign out_ch.rx_data    = o_rxd_r;
  assign out_ch.finished   = o_fin_r;
  assign out_ch.succeeded  = o_ok_r;
  assign out_ch.accepted   = o_acc_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && o_acc_r |-> o_action_r == i2cseq_pkg::ACT_START)
    else $error("accepted request without start");

  a_finish_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && o_fin_r |->
      (o_action_r == i2cseq_pkg::ACT_STOP && !o_ok_r) ||
      (o_action_r == i2cseq_pkg::ACT_NONE && o_ok_r))
    else $error("bad finish word");

  a_rx_with_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && o_rxv_r |-> o_action_r == i2cseq_pkg::ACT_ACK)
    else $error("received byte without ack action");

  a_s1_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !move |=> s1_v_r && $stable(s1_r))
    else $error("stage 1 word lost");

  a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !take |=> $stable(tx_byte_sel))
    else $error("store read data changed under a held word");

endmodule

`default_nettype wire

>>> sv/i2cseq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/i2cseq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cseq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire i2cseq_pkg::req_t  req,
  output i2cseq_pkg::step_t      step
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_WR_ADDR, PH_WR_CMD, PH_WR_DATA, PH_WR_STOP, PH_RD_START,
    PH_RD_ADDR, PH_RECEN, PH_RECSTORE, PH_REREC, PH_RD_STOP, PH_DONE
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [6:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic       kind_r, kind_nxt;
  logic [4:0] ccnt_r, ccnt_nxt;
  logic [6:0] tcnt_r, tcnt_nxt;
  logic [6:0] rcnt_r, rcnt_nxt;

  always_comb begin
    logic [6:0] idx_inc;
    logic       fail;
    idx_inc   = idx_r + 7'd1;
    fail      = 1'b0;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    busy_nxt  = busy_r;
    addr_nxt  = addr_r;
    kind_nxt  = kind_r;
    ccnt_nxt  = ccnt_r;
    tcnt_nxt  = tcnt_r;
    rcnt_nxt  = rcnt_r;
    step          = '0;
    step.action   = i2cseq_pkg::ACT_NONE;
    step.src      = i2cseq_pkg::SRC_LITERAL;
    step.rd_idx   = idx_r;

    if (take) begin
      case (req.mode)
        i2cseq_pkg::MODE_REQUEST: begin
          if (!busy_r) begin
            busy_nxt    = 1'b1;
            kind_nxt    = req.transfer_kind;
            addr_nxt    = req.device_address;
            ccnt_nxt    = req.command_length;
            tcnt_nxt    = req.tx_length;
            rcnt_nxt    = req.rx_length;
            idx_nxt     = '0;
            phase_nxt   = req.transfer_kind ? PH_RD_ADDR : PH_WR_ADDR;
            step.action = i2cseq_pkg::ACT_START;
            step.acc    = 1'b1;
          end
        end
        i2cseq_pkg::MODE_EVENT: begin
          case (phase_r)
            PH_WR_ADDR: begin
              step.action   = i2cseq_pkg::ACT_TX;
              step.byte_val = addr_r & i2cseq_pkg::ADDR_WRITE_MASK;
              phase_nxt     = PH_WR_CMD;
            end
            PH_WR_CMD: begin
              if (req.ack_status) begin
                fail = 1'b1;
              end else if (ccnt_r == 5'd0) begin
                step.action = i2cseq_pkg::ACT_STOP;
                phase_nxt   = PH_DONE;
              end else begin
                step.action = i2cseq_pkg::ACT_TX;
                step.src    = i2cseq_pkg::SRC_CMD;
                idx_nxt     = idx_inc;
                if (idx_inc >= {2'b00, ccnt_r}) begin
                  idx_nxt = '0;
                  if (kind_r) begin
                    phase_nxt = (rcnt_r != 7'd0) ? PH_RECEN : PH_WR_STOP;
                  end else if (rcnt_r != 7'd0) begin
                    phase_nxt = PH_RD_START;
                  end else begin
                    phase_nxt = (tcnt_r != 7'd0) ? PH_WR_DATA : PH_WR_STOP;
                  end
                end
              end
            end
            PH_WR_DATA: begin
              if (req.ack_status) begin
                fail = 1'b1;
              end else begin
                step.action = i2cseq_pkg::ACT_TX;
                step.src    = i2cseq_pkg::SRC_TX;
                idx_nxt     = idx_inc;
                if (idx_inc >= tcnt_r) begin
                  phase_nxt = (rcnt_r != 7'd0) ? PH_RD_START : PH_WR_STOP;
                end
              end
            end
            PH_WR_STOP, PH_RD_STOP: begin
              step.action = i2cseq_pkg::ACT_STOP;
              phase_nxt   = PH_DONE;
            end
            PH_RD_START: begin
              idx_nxt     = '0;
              step.action = i2cseq_pkg::ACT_START;
              phase_nxt   = PH_RD_ADDR;
            end
            PH_RD_ADDR: begin
              step.action   = i2cseq_pkg::ACT_TX;
              step.byte_val = addr_r | i2cseq_pkg::ADDR_READ_BIT;
              idx_nxt       = '0;
              phase_nxt     = (kind_r && ccnt_r != 5'd0) ? PH_WR_CMD : PH_RECEN;
            end
            PH_RECEN: begin
              if (req.ack_status) begin
                fail = 1'b1;
              end else begin
                step.action = i2cseq_pkg::ACT_RCEN;
                phase_nxt   = PH_RECSTORE;
              end
            end
            PH_REREC: begin
              step.action = i2cseq_pkg::ACT_RCEN;
              phase_nxt   = PH_RECSTORE;
            end
            PH_RECSTORE: begin
              step.rxv    = 1'b1;
              step.rxi    = idx_r[5:0];
              step.rxd    = req.bus_rx_byte;
              step.action = i2cseq_pkg::ACT_ACK;
              idx_nxt     = idx_inc;
              if (idx_inc >= rcnt_r) begin
                step.nack = 1'b1;
                phase_nxt = PH_RD_STOP;
              end else begin
                phase_nxt = PH_REREC;
              end
            end
            PH_DONE: begin
              step.fin  = 1'b1;
              step.ok   = 1'b1;
              busy_nxt  = 1'b0;
              phase_nxt = PH_IDLE;
            end
            default: begin
            end
          endcase
          if (fail) begin
            step.action = i2cseq_pkg::ACT_STOP;
            step.fin    = 1'b1;
            step.ok     = 1'b0;
            busy_nxt    = 1'b0;
            phase_nxt   = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      busy_r  <= 1'b0;
      addr_r  <= '0;
      kind_r  <= 1'b0;
      ccnt_r  <= '0;
      tcnt_r  <= '0;
      rcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      busy_r  <= busy_nxt;
      addr_r  <= addr_nxt;
      kind_r  <= kind_nxt;
      ccnt_r  <= ccnt_nxt;
      tcnt_r  <= tcnt_nxt;
      rcnt_r  <= rcnt_nxt;
    end
  end

endmodule

`default_nettype wire
